[hdl/dmvm_pkg.sv]
// ----------------------------------------------------------------------------
// dmvm_pkg: shared types, constants and float arithmetic
// Item types for both channels, configuration register indexes and the
// single-precision multiply and add used by the multiply-accumulate block.
// ----------------------------------------------------------------------------
package dmvm_pkg;

  // Number of lane accumulators; the reduction tree is built for eight.
  localparam int unsigned LaneCount = 8;
  localparam int unsigned LaneW     = 3;
  localparam int unsigned RowIdxW   = 12;
  localparam int unsigned NumColsW  = 13;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 13;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgAddMode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgNumCols = 1'b1;

  // Float constants.
  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;

  typedef struct packed {
    logic [31:0] matrix_value;
    logic [31:0] source_value;
    logic [31:0] prior_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0]         row_sum;
    logic [RowIdxW-1:0]  row_index;
  } out_item_t;

  // Row data that travels alongside the partial sums.
  typedef struct packed {
    logic [31:0]        prior_value;
    logic               add_mode;
    logic [RowIdxW-1:0] row_index;
  } row_meta_t;

  typedef logic [LaneCount-1:0][31:0] lane_vec_t;

  // Lane snapshot handed from the accumulator to the reduction tree.
  typedef struct packed {
    lane_vec_t lanes;
    row_meta_t meta;
  } lane_snap_t;

  // Count of leading zeros in a 48-bit word.
  function automatic logic [5:0] clz48(input logic [47:0] x);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (x[i]) begin
        n = 6'(47 - i);
      end
    end
    return n;
  endfunction

  // Round to nearest even and pack; e is the biased exponent (at least one).
  function automatic logic [31:0] fp_round(input logic sign, input logic signed [10:0] e,
                                           input logic [23:0] mant, input logic g,
                                           input logic st);
    logic              up;
    logic [24:0]       m25;
    logic [23:0]       m;
    logic signed [10:0] ex;
    logic [31:0]       r;
    up  = g & (st | mant[0]);
    m25 = {1'b0, mant} + {24'd0, up};
    ex  = e;
    if (m25[24]) begin
      m  = m25[24:1];
      ex = e + 11'sd1;
    end else begin
      m = m25[23:0];
    end
    if (ex >= 11'sd255) begin
      r = {sign, 8'hFF, 23'd0};
    end else begin
      r = {sign, (m[23] ? ex[7:0] : 8'd0), m[22:0]};
    end
    return r;
  endfunction

  // Single-precision multiply, round to nearest even.
  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic              s;
    logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0]        eaf, ebf;
    logic [23:0]       ma, mb;
    logic [47:0]       p, pn, pr;
    logic [5:0]        lz, sh;
    logic signed [10:0] e, shv;
    logic              st;
    logic [31:0]       r;
    s      = a[31] ^ b[31];
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    eaf    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    ebf    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    p      = ma * mb;
    lz     = clz48(p);
    pn     = p << lz;
    e      = $signed({3'b000, eaf}) + $signed({3'b000, ebf}) - 11'sd126
             - $signed({5'b00000, lz});
    pr     = pn;
    st     = 1'b0;
    // Results below the normal range are shifted down into a subnormal.
    if (e < 11'sd1) begin
      shv = 11'sd1 - e;
      sh  = (shv > 11'sd48) ? 6'd48 : shv[5:0];
      pr  = pn >> sh;
      st  = ((pr << sh) != pn);
      e   = 11'sd1;
    end
    if (a_nan) begin
      r = a | QuietBit;
    end else if (b_nan) begin
      r = b | QuietBit;
    end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
      r = DefaultNan;
    end else if (a_inf || b_inf) begin
      r = {s, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      r = {s, 31'd0};
    end else begin
      r = fp_round(s, e, pr[47:24], pr[23], (|pr[22:0]) | st);
    end
    return r;
  endfunction

  // Single-precision add, round to nearest even.
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic              a_nan, b_nan, a_inf, b_inf;
    logic [31:0]       x, y, r;
    logic [7:0]        ex, ey, d, lim;
    logic [4:0]        sh;
    logic [5:0]        lz, sh2;
    logic [26:0]       mx, my, mys, myal, r27;
    logic [27:0]       s28;
    logic              st;
    logic signed [10:0] e;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    // Order the operands by magnitude.
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    ex   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx   = {x[30:23] != 8'd0, x[22:0], 3'b000};
    my   = {y[30:23] != 8'd0, y[22:0], 3'b000};
    d    = ex - ey;
    sh   = (d > 8'd27) ? 5'd27 : d[4:0];
    mys  = my >> sh;
    st   = ((mys << sh) != my);
    myal = mys | {26'd0, st};
    if (x[31] ^ y[31]) begin
      s28 = {1'b0, mx} - {1'b0, myal};
    end else begin
      s28 = {1'b0, mx} + {1'b0, myal};
    end
    // Normalize: one step right on carry, else left but not below exponent one.
    lim = ex - 8'd1;
    lz  = clz48({s28[26:0], 21'd0});
    sh2 = 6'd0;
    if (s28[27]) begin
      r27 = {s28[27:2], s28[1] | s28[0]};
      e   = $signed({3'b000, ex}) + 11'sd1;
    end else begin
      sh2 = ({2'b00, lz} < lim) ? lz : lim[5:0];
      r27 = s28[26:0] << sh2;
      e   = $signed({3'b000, ex}) - $signed({5'b00000, sh2});
    end
    if (a_nan) begin
      r = a | QuietBit;
    end else if (b_nan) begin
      r = b | QuietBit;
    end else if (a_inf && b_inf && (a[31] != b[31])) begin
      r = DefaultNan;
    end else if (a_inf) begin
      r = a;
    end else if (b_inf) begin
      r = b;
    end else if (s28 == 28'd0) begin
      r = {a[31] & b[31], 31'd0};
    end else begin
      r = fp_round(x[31], e, r27[26:3], r27[2], r27[1] | r27[0]);
    end
    return r;
  endfunction

endpackage

[hdl/dmvm_mac.sv]
// ----------------------------------------------------------------------------
// dmvm_mac: input register, multiplier stage and lane accumulators
// Registers each item, multiplies, adds the product into its lane and hands
// a snapshot of all lanes to the reduction tree at the end of each row.
// ----------------------------------------------------------------------------
module dmvm_mac #(
  parameter int unsigned MAX_COLS = 4096,
  parameter int unsigned MAX_ROWS = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                add_mode_i,
  input  logic [dmvm_pkg::NumColsW-1:0]       num_cols_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dmvm_pkg::in_item_t                  in_data_i,
  output logic                                snap_valid_o,
  input  logic                                snap_stall_i,
  output dmvm_pkg::lane_snap_t                snap_data_o
);
  import dmvm_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_COLS);
  localparam int unsigned RowW = $clog2(MAX_ROWS);
  localparam int unsigned CmpW = (ColW + 1 > NumColsW) ? ColW + 1 : NumColsW;

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [CmpW-1:0]  cols_raw, cols_eff;
  logic             last_in;

  logic             v0_q, v1_q;
  in_item_t         item0_q;
  logic             last0_q, last1_q;
  logic [LaneW-1:0] lane0_q, lane1_q;
  row_meta_t        meta0_q, meta1_q;
  logic [31:0]      prod1_q;

  lane_vec_t        lanes_q, lanes_d, lanes_upd;
  logic [31:0]      acc_sum;
  logic             s1_fire, s1_ready, s0_ready, in_fire;

  // Effective column count: multiple of eight, clamped to the supported range.
  always_comb begin
    cols_raw = CmpW'({num_cols_i[NumColsW-1:LaneW], {LaneW{1'b0}}});
    if (cols_raw < CmpW'(LaneCount)) begin
      cols_eff = CmpW'(LaneCount);
    end else if (cols_raw > CmpW'(MAX_COLS)) begin
      cols_eff = CmpW'(MAX_COLS);
    end else begin
      cols_eff = cols_raw;
    end
  end

  assign last_in = (CmpW'(col_q) + CmpW'(1)) >= cols_eff;
  assign col_d   = last_in ? '0 : col_q + ColW'(1);
  assign row_d   = (row_q == RowW'(MAX_ROWS - 1)) ? '0 : row_q + RowW'(1);

  // Handshake: the accumulate stage only waits when a row end meets a full tree.
  assign s1_fire    = v1_q && (!last1_q || !snap_stall_i);
  assign s1_ready   = !v1_q || s1_fire;
  assign s0_ready   = !v0_q || s1_ready;
  assign in_stall_o = !s0_ready;
  assign in_fire    = in_valid_i && s0_ready;

  // Column and row position of the next item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      if (last_in) begin
        row_q <= row_d;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (s0_ready) begin
        v0_q <= in_valid_i;
      end
      if (s1_ready) begin
        v1_q <= v0_q;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item0_q             <= in_data_i;
      last0_q             <= last_in;
      lane0_q             <= col_q[LaneW-1:0];
      meta0_q.prior_value <= in_data_i.prior_value;
      meta0_q.add_mode    <= add_mode_i;
      meta0_q.row_index   <= RowIdxW'(row_q);
    end
  end

  // Product register.
  always_ff @(posedge clk_i) begin
    if (s1_ready && v0_q) begin
      prod1_q <= fp_mul(item0_q.matrix_value, item0_q.source_value);
      last1_q <= last0_q;
      lane1_q <= lane0_q;
      meta1_q <= meta0_q;
    end
  end

  // Lane update: add the product, clear all lanes at the end of a row.
  assign acc_sum = fp_add(lanes_q[lane1_q], prod1_q);

  always_comb begin
    for (int k = 0; k < LaneCount; k++) begin
      lanes_upd[k] = (LaneW'(k) == lane1_q) ? acc_sum : lanes_q[k];
      lanes_d[k]   = last1_q ? 32'd0 : lanes_upd[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= '0;
    end else if (s1_fire) begin
      lanes_q <= lanes_d;
    end
  end

  assign snap_valid_o      = v1_q && last1_q;
  assign snap_data_o.lanes = lanes_upd;
  assign snap_data_o.meta  = meta1_q;

endmodule

[hdl/dmvm_reduce.sv]
// ----------------------------------------------------------------------------
// dmvm_reduce: pipelined pairwise reduction of the lanes
// Four register stages sum the eight lanes in a fixed tree order, then the
// last stage adds the prior value in add mode and holds the result item.
// ----------------------------------------------------------------------------
module dmvm_reduce (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  snap_valid_i,
  output logic                  snap_stall_o,
  input  dmvm_pkg::lane_snap_t  snap_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dmvm_pkg::out_item_t   out_data_o
);
  import dmvm_pkg::*;

  logic [4:0]       v_q;
  logic [4:0]       rdy;
  lane_snap_t       snap_q;
  logic [3:0][31:0] s1_q;
  logic [1:0][31:0] s2_q;
  logic [31:0]      s3_q;
  row_meta_t        m1_q, m2_q, m3_q;
  out_item_t        out_q;

  // Each stage takes a new item when empty or when it moves on; the chain is
  // built from the output end so every stage sees its successor's value.
  always_comb begin
    rdy[4] = !v_q[4] || !out_stall_i;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign snap_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= snap_valid_i;
      end
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Snapshot of the finished lanes.
  always_ff @(posedge clk_i) begin
    if (rdy[0] && snap_valid_i) begin
      snap_q <= snap_data_i;
    end
  end

  // Pairs of neighboring lanes.
  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      for (int k = 0; k < 4; k++) begin
        s1_q[k] <= fp_add(snap_q.lanes[2*k], snap_q.lanes[2*k+1]);
      end
      m1_q <= snap_q.meta;
    end
  end

  // Low and high halves.
  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      s2_q[0] <= fp_add(s1_q[0], s1_q[1]);
      s2_q[1] <= fp_add(s1_q[2], s1_q[3]);
      m2_q    <= m1_q;
    end
  end

  // Row total.
  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_q[2]) begin
      s3_q <= fp_add(s2_q[0], s2_q[1]);
      m3_q <= m2_q;
    end
  end

  // Optional prior value and the result register.
  always_ff @(posedge clk_i) begin
    if (rdy[4] && v_q[3]) begin
      out_q.row_sum   <= m3_q.add_mode ? fp_add(s3_q, m3_q.prior_value) : s3_q;
      out_q.row_index <= m3_q.row_index;
    end
  end

  assign out_valid_o = v_q[4];
  assign out_data_o  = out_q;

endmodule

[hdl/dense_matrix_vector_mac.sv]
// ----------------------------------------------------------------------------
// dense_matrix_vector_mac: streaming single-precision matrix-vector product
// Accumulates one matrix row per group of items and emits the row sum.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive in row-major order on the input channel; each carries a matrix
// element, the source element for its column and the row's old destination
// value. An item is taken at each clock edge where in_valid_i is high and
// in_stall_o is low. The block accepts one item per cycle unless stalled.
// Items pass the input and product registers into their lanes; row results
// reach out_valid_o via the lane snapshot, the three-level add tree and the
// optional prior-value add. Only the last item of a row makes a result.
// When out_stall_i holds a result, the tree keeps taking row ends until its
// five stages are full; items of the row in progress keep flowing until a row
// end meets a full tree. Reset clears the lanes, the column and row counters,
// sets add mode off and the column count to eight. Configuration writes are
// taken on any cycle with cfg_we_i high and belong between rows.
// ----------------------------------------------------------------------------
module dense_matrix_vector_mac #(
  parameter int unsigned MAX_COLS = 4096,
  parameter int unsigned MAX_ROWS = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dmvm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dmvm_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  dmvm_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dmvm_pkg::out_item_t               out_data_o
);
  import dmvm_pkg::*;

  logic                add_mode_q;
  logic [NumColsW-1:0] num_cols_q;
  logic                snap_valid, snap_stall;
  lane_snap_t          snap_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_mode_q <= 1'b0;
      num_cols_q <= NumColsW'(LaneCount);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAddMode: add_mode_q <= cfg_data_i[0];
        CfgNumCols: num_cols_q <= cfg_data_i[NumColsW-1:0];
        default: ;
      endcase
    end
  end

  // Multiply and lane accumulation.
  dmvm_mac #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .add_mode_i   (add_mode_q),
    .num_cols_i   (num_cols_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .snap_valid_o (snap_valid),
    .snap_stall_i (snap_stall),
    .snap_data_o  (snap_data)
  );

  // Lane reduction and result register.
  dmvm_reduce u_reduce (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_stall_o (snap_stall),
    .snap_data_i  (snap_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

[tb/sv/dense_matrix_vector_mac_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_matrix_vector_mac_tb: regression for the matrix-vector MAC
// Streams rows of single-precision items through the block under random
// input gaps and output stalls. A behavioral model of the lane accumulators
// and the reduction tree predicts each row sum and row index, and every
// result is checked in order against it.
// ----------------------------------------------------------------------------
module dense_matrix_vector_mac_tb;
  import dmvm_pkg::*;

  localparam logic [31:0] CanonNan = 32'hFFC0_0000;
  localparam logic [31:0] QuietMsk = 32'h0040_0000;
  localparam int unsigned ColLimit = 4096;
  localparam int unsigned RowLimit = 4096;
  localparam int unsigned DrainCycles = 20;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_data_o;

  dense_matrix_vector_mac DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Items waiting to be driven and row sums waiting to come out.
  in_item_t  item_queue[$];
  out_item_t pending_sums[$];
  int        fail_count;
  bit        gap_free;

  // Shadow copy of the block state.
  logic [31:0] lane_acc[LaneCount];
  int unsigned col_pos;
  int unsigned row_pos;
  logic        add_mode_q;
  logic [12:0] num_cols_q;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Float bits to real; NaN never reaches here.
  function automatic real bits_to_real(input logic [31:0] f);
    real v;
    if (f[30:23] == 8'd0) begin
      v = real'(f[22:0]) * (2.0 ** -149);
      if (f[31]) begin
        v = -v;
      end
    end else if (f[30:23] == 8'hFF) begin
      v = $bitstoreal({f[31], 11'h7FF, 52'd0});
    end else begin
      v = $bitstoreal({f[31], 11'(f[30:23]) + 11'd896, f[22:0], 29'd0});
    end
    return v;
  endfunction

  // Real to float bits, round to nearest even. Rounding a double result of
  // a single float operation once more gives the correctly rounded float.
  function automatic logic [31:0] real_to_bits(input real v);
    logic [63:0] d, m, q, rem, half;
    int          e, shift;
    d = $realtobits(v);
    if (d[62:52] == 11'd0) begin
      return {d[63], 31'd0};
    end
    if (d[62:52] == 11'h7FF) begin
      return {d[63], 8'hFF, 23'd0};
    end
    e = int'(d[62:52]) - 1023;
    m = {11'd0, 1'b1, d[51:0]};
    shift = (e >= -126) ? 29 : 29 + (-126 - e);
    if (shift > 60) begin
      shift = 60;
    end
    q    = m >> shift;
    rem  = m & ((64'd1 << shift) - 64'd1);
    half = 64'd1 << (shift - 1);
    if (rem > half || (rem == half && q[0])) begin
      q = q + 64'd1;
    end
    if (e >= -126) begin
      if (q == (64'd1 << 24)) begin
        q = q >> 1;
        e = e + 1;
      end
      if (e > 127) begin
        return {d[63], 8'hFF, 23'd0};
      end
      return {d[63], 8'(e + 127), q[22:0]};
    end
    // Subnormal; a carry into bit 23 lands on the smallest normal.
    return {d[63], q[30:0]};
  endfunction

  function automatic bit is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

  function automatic bit is_inf(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
  endfunction

  function automatic logic [31:0] flt_mul(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a)) begin
      return a | QuietMsk;
    end
    if (is_nan(b)) begin
      return b | QuietMsk;
    end
    if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0)) begin
      return CanonNan;
    end
    return real_to_bits(bits_to_real(a) * bits_to_real(b));
  endfunction

  function automatic logic [31:0] flt_add(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a)) begin
      return a | QuietMsk;
    end
    if (is_nan(b)) begin
      return b | QuietMsk;
    end
    if (is_inf(a) && is_inf(b) && (a[31] != b[31])) begin
      return CanonNan;
    end
    return real_to_bits(bits_to_real(a) + bits_to_real(b));
  endfunction

  function automatic int unsigned row_length();
    int unsigned c;
    c = int'(num_cols_q) & ~(LaneCount - 1);
    if (c < LaneCount) begin
      c = LaneCount;
    end
    if (c > ColLimit) begin
      c = ColLimit;
    end
    return c;
  endfunction

  function automatic void clear_lanes();
    for (int i = 0; i < LaneCount; i++) begin
      lane_acc[i] = 32'd0;
    end
  endfunction

  // Add one product into its lane; at row end reduce and queue the sum.
  function automatic void accumulate_item(input in_item_t it);
    logic [31:0] p01, p23, p45, p67, total;
    out_item_t   res;
    lane_acc[col_pos % LaneCount] =
      flt_add(lane_acc[col_pos % LaneCount], flt_mul(it.matrix_value, it.source_value));
    if (col_pos + 1 < row_length()) begin
      col_pos++;
      return;
    end
    p01   = flt_add(lane_acc[0], lane_acc[1]);
    p23   = flt_add(lane_acc[2], lane_acc[3]);
    p45   = flt_add(lane_acc[4], lane_acc[5]);
    p67   = flt_add(lane_acc[6], lane_acc[7]);
    total = flt_add(flt_add(p01, p23), flt_add(p45, p67));
    if (add_mode_q) begin
      total = flt_add(total, it.prior_value);
    end
    res.row_sum   = total;
    res.row_index = RowIdxW'(row_pos);
    pending_sums.push_back(res);
    clear_lanes();
    col_pos = 0;
    row_pos = (row_pos + 1 >= RowLimit) ? 0 : row_pos + 1;
  endfunction

  // Gap length for either side: mostly short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (gap_free) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Random float bit pattern spread over all classes.
  function automatic logic [31:0] pick_float();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      return {1'($urandom), 31'd0};
    end else if (r < 5) begin
      return {1'($urandom), 8'hFF, 23'd0};
    end else if (r < 7) begin
      return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
    end else if (r < 10) begin
      return {1'($urandom), 8'd0, 23'($urandom)};
    end else if (r < 15) begin
      return $urandom;
    end
    return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
  endfunction

  function automatic in_item_t pick_item();
    in_item_t it;
    it.matrix_value = pick_float();
    it.source_value = pick_float();
    it.prior_value  = pick_float();
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %0t: %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Register write; the shadow state changes when the write is driven, before the block takes it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [12:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == CfgAddMode) begin
      add_mode_q = val[0];
    end else begin
      num_cols_q = val;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Let every queued item go in and every expected sum come out.
  task automatic drain();
    while (item_queue.size() != 0 || in_valid_i || pending_sums.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_rows(input int unsigned rows);
    repeat (rows * row_length()) item_queue.push_back(pick_item());
  endtask

  // Input driver: holds a stalled item, otherwise feeds the next one.
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap     = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        accumulate_item(in_data_i);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (item_queue.size() != 0) begin
          in_data_i  <= item_queue.pop_front();
          in_valid_i <= 1'b1;
          in_gap     = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each accepted result, then picks the next stall.
  int unsigned out_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap     = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_sums.size() == 0) begin
          report_mismatch("unexpected row sum", out_data_o.row_sum, 32'd0);
        end else begin
          if (out_data_o.row_sum !== pending_sums[0].row_sum) begin
            report_mismatch("row_sum", out_data_o.row_sum, pending_sums[0].row_sum);
          end
          if (out_data_o.row_index !== pending_sums[0].row_index) begin
            report_mismatch("row_index", 32'(out_data_o.row_index),
                            32'(pending_sums[0].row_index));
          end
          void'(pending_sums.pop_front());
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_gap     = pick_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus phases.
  initial begin
    logic [12:0] col_set[9];
    fail_count = 0;
    gap_free   = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    add_mode_q = 1'b0;
    num_cols_q = 13'd8;
    col_pos    = 0;
    row_pos    = 0;
    clear_lanes();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows at reset settings: special operands of every kind.
    item_queue.push_back('{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF});
    item_queue.push_back('{32'h7F80_0000, 32'h0000_0000, 32'h0000_0000});
    item_queue.push_back('{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0000});
    item_queue.push_back('{32'h0000_0001, 32'h3F00_0000, 32'h0000_0000});
    item_queue.push_back('{32'h8000_0000, 32'h3F80_0000, 32'h0000_0000});
    item_queue.push_back('{32'hFF80_0000, 32'h3F80_0000, 32'h0000_0000});
    item_queue.push_back('{32'h0080_0000, 32'h0080_0000, 32'h0000_0000});
    item_queue.push_back('{32'h7FA0_0001, 32'h7FC0_0002, 32'h0000_0000});
    // Opposite infinities in separate lanes, then plain products; the row sum is NaN.
    item_queue.push_back('{32'h7F80_0000, 32'h3F80_0000, 32'h0000_0000});
    item_queue.push_back('{32'hFF80_0000, 32'h3F80_0000, 32'h0000_0000});
    repeat (6) item_queue.push_back('{32'h3F80_0000, 32'h4000_0000, 32'h0000_0000});
    // Negative zero products only: the lanes start at positive zero, so the
    // sum is positive zero.
    repeat (8) item_queue.push_back('{32'h8000_0000, 32'h3F80_0000, 32'hFFFF_FFFF});
    drain();

    // Add mode with prior values of the extremes.
    write_reg(CfgAddMode, 13'd1);
    repeat (7) item_queue.push_back('{32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000});
    item_queue.push_back('{32'h3F80_0000, 32'h3F80_0000, 32'hC100_0000});
    repeat (7) item_queue.push_back('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
    item_queue.push_back('{32'h0000_0000, 32'h0000_0000, 32'h7FC1_2345});
    drain();

    // Column count changed inside a row: the next item closes it.
    write_reg(CfgNumCols, 13'd64);
    repeat (20) item_queue.push_back(pick_item());
    drain();
    write_reg(CfgNumCols, 13'd16);
    queue_rows(3);
    drain();

    // Random phases over a spread of settings, the small extremes among them.
    col_set = '{13'd8, 13'd0, 13'd5, 13'd13, 13'd16, 13'd24, 13'd64, 13'd7, 13'd128};
    for (int ph = 0; ph < 12; ph++) begin
      logic [12:0] c;
      int unsigned rows;
      c = (ph < 9) ? col_set[ph] : col_set[$urandom_range(0, 6)];
      write_reg(CfgAddMode, 13'($urandom_range(0, 1)));
      write_reg(CfgNumCols, c);
      gap_free = ($urandom_range(0, 3) == 0);
      rows = (row_length() >= 96) ? 1 : 96 / row_length();
      queue_rows(rows);
      drain();
    end
    gap_free = 1'b0;

    if (fail_count == 0) begin
      $display("dense_matrix_vector_mac regression: pass");
    end else begin
      $display("dense_matrix_vector_mac regression: fail");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #40ms;
    $display("dense_matrix_vector_mac regression: fail");
    $finish;
  end

endmodule
